// ===== rtl/bwh_pkg.sv =====
// Shared constants, codes and control types for the bit window histogram block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bwh_pkg;

  localparam int OP_W          = 2;
  localparam int INDEX_W       = 8;
  localparam int FIELD_W       = 48;
  localparam int WINDOW_BITS_W = 4;
  localparam int MAX_RUN_W     = 6;
  localparam int LIMIT_W       = 48;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 48;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 200;
  localparam int OUT_PAD_W     = OUT_TDATA_W - 4 * FIELD_W - 1;

  localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_BIN = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_RUN = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_BITS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RUN      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_LIMIT = 2'd2;

  localparam logic [WINDOW_BITS_W-1:0] WINDOW_BITS_RST = 4'd1;
  localparam logic [MAX_RUN_W-1:0]     MAX_RUN_RST     = 6'd32;

  typedef struct packed {
    logic accept;
    logic push_upd;
    logic clr_scalars;
    logic clr_we;
    logic bin_rd;
    logic bin_wr;
    logic run_rd;
    logic run_wr;
    logic load_out;
  } bwh_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            at_limit;
  } bwh_sts_t;

endpackage

// ===== rtl/bwh_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the histogram bins and the run counters.
module bwh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bwh_ctrl.sv =====
// Sequencing state machine: clearing sweep, decode, run counter loop and result load.
// Depends on bwh_pkg; drives the datapath through bwh_cmd_t and reads bwh_sts_t.
module bwh_ctrl #(
  parameter int WINDOW_MAX = 8,
  parameter int MAX_RUN    = 32,
  parameter int LEN_W      = $clog2(MAX_RUN + 1),
  parameter int RUN_AW     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1,
  parameter int SWEEP      = ((1 << WINDOW_MAX) > MAX_RUN) ? (1 << WINDOW_MAX) : MAX_RUN,
  parameter int SW_AW      = $clog2(SWEEP)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  bwh_pkg::bwh_sts_t   sts,
  input  logic [LEN_W-1:0]    loop_len,
  output bwh_pkg::bwh_cmd_t   cmd,
  output logic [RUN_AW-1:0]   run_j,
  output logic [SW_AW-1:0]    clr_addr
);
  import bwh_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic             pend_r, pend_nxt;
  logic             binrd_r, binrd_nxt;
  logic             binwr_r, binwr_nxt;
  logic [SW_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_resp_r, clr_resp_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rd_go;

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    binrd_nxt     = binrd_r;
    binwr_nxt     = binwr_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_resp_nxt  = clr_resp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    rd_go         = j_r < loop_len;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (clr_cnt_r == SW_AW'(SWEEP - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_resp_r ? S_DONE : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + SW_AW'(1);
        end
      end
      S_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_PUSH: begin
            if (sts.at_limit) begin
              state_nxt = S_DONE;
            end else begin
              cmd.push_upd = 1'b1;
              j_nxt        = '0;
              pend_nxt     = 1'b0;
              binrd_nxt    = 1'b1;
              binwr_nxt    = 1'b0;
              state_nxt    = S_RUN;
            end
          end
          OP_READ_BIN: begin
            cmd.bin_rd = 1'b1;
            state_nxt  = S_DONE;
          end
          OP_READ_RUN: begin
            cmd.run_rd = 1'b1;
            state_nxt  = S_DONE;
          end
          default: begin
            cmd.clr_scalars = 1'b1;
            clr_resp_nxt    = 1'b1;
            clr_cnt_nxt     = '0;
            state_nxt       = S_CLEAR;
          end
        endcase
      end
      S_RUN: begin
        cmd.run_rd = rd_go;
        cmd.run_wr = pend_r;
        cmd.bin_rd = binrd_r;
        cmd.bin_wr = binwr_r;
        pend_nxt   = rd_go;
        binrd_nxt  = 1'b0;
        binwr_nxt  = binrd_r;
        if (rd_go) begin
          j_nxt = j_r + LEN_W'(1);
        end
        if (!rd_go && !binrd_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
        clr_resp_nxt  = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      j_r         <= '0;
      pend_r      <= 1'b0;
      binrd_r     <= 1'b0;
      binwr_r     <= 1'b0;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      pend_r      <= pend_nxt;
      binrd_r     <= binrd_nxt;
      binwr_r     <= binwr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign run_j      = j_r[RUN_AW-1:0];
  assign clr_addr   = clr_cnt_r;

endmodule

// ===== rtl/bwh_datapath.sv =====
// Datapath: configuration registers, window and run state, counter memories and result register.
// Depends on bwh_pkg and bwh_ram; steered by the controller through bwh_cmd_t.
module bwh_datapath #(
  parameter int WINDOW_MAX = 8,
  parameter int MAX_RUN    = 32,
  parameter int COUNT_BITS = 48,
  parameter int LEN_W      = $clog2(MAX_RUN + 1),
  parameter int RUN_AW     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1,
  parameter int SWEEP      = ((1 << WINDOW_MAX) > MAX_RUN) ? (1 << WINDOW_MAX) : MAX_RUN,
  parameter int SW_AW      = $clog2(SWEEP)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bwh_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bwh_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [bwh_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  bwh_pkg::bwh_cmd_t                   cmd,
  input  logic [RUN_AW-1:0]                   run_j,
  input  logic [SW_AW-1:0]                    clr_addr,
  output bwh_pkg::bwh_sts_t                   sts,
  output logic [LEN_W-1:0]                    loop_len,
  output logic [bwh_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import bwh_pkg::*;

  localparam int BIN_AW  = WINDOW_MAX;
  localparam int BIN_CNT = 1 << WINDOW_MAX;
  localparam int XW      = (BIN_AW > INDEX_W) ? BIN_AW : INDEX_W;
  localparam int LIM_CW  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int CW      = COUNT_BITS;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == '1) ? v : v + CW'(1);
  endfunction

  function automatic logic [LEN_W-1:0] run_inc(input logic [LEN_W-1:0] v);
    return (v >= LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : v + LEN_W'(1);
  endfunction

  logic [WINDOW_BITS_W-1:0] window_bits_r;
  logic [MAX_RUN_W-1:0]     max_run_r;
  logic [LIMIT_W-1:0]       sample_limit_r;

  logic [OP_W-1:0]          op_r;
  logic                     bit_r;
  logic [INDEX_W-1:0]       idx_r;

  logic [WINDOW_MAX-1:0]    window_r, window_nxt;
  logic [CW-1:0]            bits_read_r, bits_read_nxt;
  logic [CW-1:0]            windows_r, windows_nxt;
  logic                     prev_bit_r;
  logic [LEN_W-1:0]         ones_run_r, ones_run_nxt;
  logic [LEN_W-1:0]         zeros_run_r, zeros_run_nxt;
  logic                     win_hit_r, win_hit_nxt;
  logic [RUN_AW-1:0]        run_wa_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;

  logic [WINDOW_BITS_W-1:0] n_eff;
  logic [WINDOW_MAX-1:0]    win_mask;
  logic [WINDOW_MAX:0]      win_shift;
  logic [7:0]               runs_eff;
  logic                     at_limit;

  logic [XW-1:0]            idx_x;
  logic                     bin_idx_ok;
  logic                     run_idx_ok;
  logic [RUN_AW-1:0]        run_idx_addr;

  logic                     bin_we;
  logic [BIN_AW-1:0]        bin_waddr, bin_raddr;
  logic [CW-1:0]            bin_wdata, bin_rdata;

  logic                     run_in_range;
  logic                     run_we;
  logic [RUN_AW-1:0]        run_waddr, run_raddr;
  logic [3*CW-1:0]          run_wdata, run_rdata;
  logic [CW-1:0]            ones_rd, zeros_rd, other_rd;
  logic [LEN_W-1:0]         run_len;

  logic [FIELD_W-1:0]       first_f, second_f, third_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_bits_r  <= WINDOW_BITS_RST;
      max_run_r      <= MAX_RUN_RST;
      sample_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WINDOW_BITS:  window_bits_r  <= cfg_wdata[WINDOW_BITS_W-1:0];
        CFG_MAX_RUN:      max_run_r      <= cfg_wdata[MAX_RUN_W-1:0];
        CFG_SAMPLE_LIMIT: sample_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tdata[OP_W-1:0];
      bit_r <= in_tdata[OP_W];
      idx_r <= in_tdata[OP_W+INDEX_W:OP_W+1];
    end
    if (cmd.run_rd) begin
      run_wa_r <= run_j;
    end
  end

  always_comb begin
    n_eff = (window_bits_r > WINDOW_BITS_W'(WINDOW_MAX)) ? WINDOW_BITS_W'(WINDOW_MAX)
                                                          : window_bits_r;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      win_mask[i] = WINDOW_BITS_W'(i) < n_eff;
    end
    win_shift     = {window_r, bit_r};
    window_nxt    = win_mask & win_shift[WINDOW_MAX-1:0];
    bits_read_nxt = sat_inc(bits_read_r);
    win_hit_nxt   = bits_read_nxt >= CW'(n_eff);
    windows_nxt   = win_hit_nxt ? sat_inc(windows_r) : windows_r;
    ones_run_nxt  = ones_run_r;
    zeros_run_nxt = zeros_run_r;
    if (windows_nxt != '0) begin
      if (bit_r) begin
        if (prev_bit_r) begin
          ones_run_nxt = run_inc(ones_run_r);
        end else begin
          ones_run_nxt  = LEN_W'(1);
          zeros_run_nxt = '0;
        end
      end else begin
        if (!prev_bit_r) begin
          zeros_run_nxt = run_inc(zeros_run_r);
        end else begin
          zeros_run_nxt = LEN_W'(1);
          ones_run_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_scalars) begin
      window_r    <= '0;
      bits_read_r <= '0;
      windows_r   <= '0;
      prev_bit_r  <= 1'b0;
      ones_run_r  <= '0;
      zeros_run_r <= '0;
      win_hit_r   <= 1'b0;
    end else if (cmd.push_upd) begin
      window_r    <= window_nxt;
      bits_read_r <= bits_read_nxt;
      windows_r   <= windows_nxt;
      prev_bit_r  <= bit_r;
      ones_run_r  <= ones_run_nxt;
      zeros_run_r <= zeros_run_nxt;
      win_hit_r   <= win_hit_nxt;
    end
  end

  assign at_limit = (sample_limit_r != '0) &&
                    (LIM_CW'(windows_r) >= LIM_CW'(sample_limit_r));
  assign runs_eff = (8'(max_run_r) > 8'(MAX_RUN)) ? 8'(MAX_RUN) : 8'(max_run_r);
  assign loop_len = (bits_read_r < CW'(runs_eff)) ? LEN_W'(bits_read_r) : LEN_W'(runs_eff);
  assign sts.op       = op_r;
  assign sts.at_limit = at_limit;

  assign idx_x        = XW'(idx_r);
  assign bin_idx_ok   = (idx_x >> BIN_AW) == '0;
  assign run_idx_ok   = (idx_r != '0) && (9'(idx_r) <= 9'(MAX_RUN));
  assign run_idx_addr = RUN_AW'(idx_r - 8'd1);

  assign bin_we    = cmd.clr_we || (cmd.bin_wr && win_hit_r);
  assign bin_waddr = cmd.clr_we ? clr_addr[BIN_AW-1:0] : window_r;
  assign bin_wdata = cmd.clr_we ? '0 : sat_inc(bin_rdata);
  assign bin_raddr = (op_r == OP_PUSH) ? window_r : idx_x[BIN_AW-1:0];

  bwh_ram #(
    .WIDTH (CW),
    .DEPTH (BIN_CNT),
    .AW    (BIN_AW)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (cmd.bin_rd),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  assign ones_rd      = run_rdata[CW-1:0];
  assign zeros_rd     = run_rdata[2*CW-1:CW];
  assign other_rd     = run_rdata[3*CW-1:2*CW];
  assign run_len      = LEN_W'(run_wa_r) + LEN_W'(1);
  assign run_in_range = ({1'b0, clr_addr} < (SW_AW + 1)'(MAX_RUN));

  always_comb begin
    run_wdata = run_rdata;
    if (cmd.clr_we) begin
      run_wdata = '0;
    end else if (ones_run_r >= run_len) begin
      run_wdata[CW-1:0] = sat_inc(ones_rd);
    end else if (zeros_run_r >= run_len) begin
      run_wdata[2*CW-1:CW] = sat_inc(zeros_rd);
    end else begin
      run_wdata[3*CW-1:2*CW] = sat_inc(other_rd);
    end
  end

  assign run_we    = (cmd.clr_we && run_in_range) || cmd.run_wr;
  assign run_waddr = cmd.clr_we ? clr_addr[RUN_AW-1:0] : run_wa_r;
  assign run_raddr = (op_r == OP_PUSH) ? run_j : run_idx_addr;

  bwh_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_RUN),
    .AW    (RUN_AW)
  ) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .re    (cmd.run_rd),
    .raddr (run_raddr),
    .rdata (run_rdata)
  );

  always_comb begin
    first_f  = '0;
    second_f = '0;
    third_f  = '0;
    case (op_r)
      OP_READ_BIN: begin
        if (bin_idx_ok) begin
          first_f = FIELD_W'(bin_rdata);
        end
      end
      OP_READ_RUN: begin
        if (run_idx_ok) begin
          first_f  = FIELD_W'(ones_rd);
          second_f = FIELD_W'(zeros_rd);
          third_f  = FIELD_W'(other_rd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, at_limit, FIELD_W'(windows_r),
                      third_f, second_f, first_f};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

// ===== rtl/bit_window_histogram_run_stats.sv =====
// Top level of the bit window histogram and run statistics collector.
// Depends on bwh_pkg, bwh_ctrl, bwh_datapath and bwh_ram.
//
//   Port group  Direction  Payload
//   in_*        slave      operation, bit_value, index
//   out_*       master     first/second/third counts, windows counted, limit flag
//   cfg_*       write      window_bits, max_run, sample_limit
//
// A push runs the run counter loop over L run lengths, L being the smaller of max_run
// and the bits read so far; the loop does one read and one write of the run counter
// RAM per cycle. Reads and pushes ignored at the limit skip the loop. After reset,
// and for a clear operation, a sweep over max(2^WINDOW_MAX, MAX_RUN) addresses
// (256 by default) zeroes both memories while no transfer is taken on the input side.
// A new item is taken while the previous result waits, if that result is taken in the
// same cycle.
module bit_window_histogram_run_stats #(
  parameter int WINDOW_MAX = 8,
  parameter int MAX_RUN    = 32,
  parameter int COUNT_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // operation[1:0], bit_value[2], index[10:3], zero fill
  input  logic [bwh_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // first_count[47:0], second_count[95:48], third_count[143:96],
  // windows_counted[191:144], limit_reached[192], zero fill
  output logic [bwh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [bwh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bwh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bwh_pkg::*;

  localparam int LEN_W  = $clog2(MAX_RUN + 1);
  localparam int RUN_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int SWEEP  = ((1 << WINDOW_MAX) > MAX_RUN) ? (1 << WINDOW_MAX) : MAX_RUN;
  localparam int SW_AW  = $clog2(SWEEP);

  bwh_cmd_t          cmd;
  bwh_sts_t          sts;
  logic [LEN_W-1:0]  loop_len;
  logic [RUN_AW-1:0] run_j;
  logic [SW_AW-1:0]  clr_addr;

  bwh_ctrl #(
    .WINDOW_MAX (WINDOW_MAX),
    .MAX_RUN    (MAX_RUN),
    .LEN_W      (LEN_W),
    .RUN_AW     (RUN_AW),
    .SWEEP      (SWEEP),
    .SW_AW      (SW_AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .loop_len   (loop_len),
    .cmd        (cmd),
    .run_j      (run_j),
    .clr_addr   (clr_addr)
  );

  bwh_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .MAX_RUN    (MAX_RUN),
    .COUNT_BITS (COUNT_BITS),
    .LEN_W      (LEN_W),
    .RUN_AW     (RUN_AW),
    .SWEEP      (SWEEP),
    .SW_AW      (SW_AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .run_j     (run_j),
    .clr_addr  (clr_addr),
    .sts       (sts),
    .loop_len  (loop_len),
    .out_tdata (out_tdata)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken again in the cycle after a transfer.");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_tvalid || out_tready)
    else $error("Result loaded while the output register still holds one.");

  a_run_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_wr |-> $past(cmd.run_rd))
    else $error("Run counter written without a read in the cycle before.");

  a_bin_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bin_wr |-> $past(cmd.bin_rd))
    else $error("Histogram bin written without a read in the cycle before.");

endmodule
